FILE: design/esc_pkg.sv
// shared constants and codes for the elevator stop scheduler
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

	localparam int NUM_FLOORS = 16;
	localparam int FLOOR_W    = 4;
	localparam int LOAD_W     = 13;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

	// command codes
	localparam logic [CMD_W-1:0] CMD_ADD_STOP    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_LOAD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_LOAD = 2'd2;
	localparam logic [CMD_W-1:0] CMD_STEP        = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_STOPS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERLOAD = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WEIGHT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FLOOR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOOR  = 2'd2;

	// reset values
	localparam logic [LOAD_W-1:0]  MAX_WEIGHT_RST = 13'd1000;
	localparam logic [FLOOR_W-1:0] MIN_FLOOR_RST  = 4'd1;
	localparam logic [FLOOR_W-1:0] MAX_FLOOR_RST  = 4'd15;
	localparam logic [FLOOR_W-1:0] CUR_FLOOR_RST  = 4'd1;

	typedef logic [NUM_FLOORS-1:0] stop_mask_t;
	typedef logic [FLOOR_W-1:0]    floor_t;

endpackage

`default_nettype wire

FILE: design/elevator_stop_scheduler.sv
// SCAN-style elevator controller with a serial floor scanner
`timescale 1ns / 1ps
`default_nettype none

// Commands enter on start while busy is low: cmd, floor and weight are taken at
// that edge. Every command gives exactly one result, shown for one cycle with
// done high on status, now_floor, going_up, pending_stops and cabin_load; the
// receiver takes it in that cycle and cannot hold it off.
// Add stop, add load, remove load, and a step with no stops pending finish
// without a scan: done follows the accepting edge. A step with stops pending
// walks one comparator over all NUM_FLOORS floor bits, one floor per cycle,
// then settles the turn, clear, overload and move in S_FIN, which also
// registers done. busy is high for that whole walk and for S_FIN, so a new
// command is not accepted until done is high.
// A new command may be started in the cycle that done is high.
// The register port (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while the block is idle. Index 0 is max_weight, 1 is
// min_floor, 2 is max_floor; other indexes are ignored.
// Reset clears the stop set and the load, puts the cabin on floor 1 going up
// and loads the register defaults 1000, 1 and 15; no result is pending.
module elevator_stop_scheduler (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire  [esc_pkg::CMD_W-1:0]      cmd,
	input  wire  [esc_pkg::FLOOR_W-1:0]    floor,
	input  wire  [esc_pkg::LOAD_W-1:0]     weight,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [esc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [esc_pkg::LOAD_W-1:0]     cfg_data,
	output logic                           done,
	output logic [esc_pkg::STATUS_W-1:0]   status,
	output logic [esc_pkg::FLOOR_W-1:0]    now_floor,
	output logic                           going_up,
	output logic [esc_pkg::NUM_FLOORS-1:0] pending_stops,
	output logic [esc_pkg::LOAD_W-1:0]     cabin_load
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	localparam logic [esc_pkg::FLOOR_W-1:0] LAST_IDX =
		esc_pkg::FLOOR_W'(esc_pkg::NUM_FLOORS - 1);

	logic [1:0]                     state_q;
	esc_pkg::stop_mask_t            mask_q;
	esc_pkg::floor_t                cur_q;
	logic                           dir_q;
	logic [esc_pkg::LOAD_W-1:0]     load_q;
	logic [esc_pkg::LOAD_W-1:0]     max_weight_q;
	esc_pkg::floor_t                min_floor_q;
	esc_pkg::floor_t                max_floor_q;
	logic                           done_q;
	logic [esc_pkg::STATUS_W-1:0]   status_q;

	// scanner state
	esc_pkg::floor_t                idx_q;
	logic                           any_above_q;
	logic                           any_below_q;
	esc_pkg::floor_t                near_above_q;
	esc_pkg::floor_t                near_below_q;

	logic                           accept;
	logic                           cfg_wr;
	logic [esc_pkg::LOAD_W:0]       load_sum;
	logic                           floor_ok;
	logic                           bit_here;
	logic                           hit_above;
	logic                           hit_below;
	logic                           cur_bit;
	logic                           dir_turn;
	logic                           dir_fin;
	esc_pkg::stop_mask_t            mask_cleared;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = (state_q != S_IDLE);

	assign load_sum = {1'b0, load_q} + {1'b0, weight};
	assign floor_ok = (floor >= min_floor_q) && (floor <= max_floor_q)
		&& ({1'b0, floor} < (esc_pkg::FLOOR_W + 1)'(esc_pkg::NUM_FLOORS));

	// shared compare unit: one floor bit against the cabin floor per cycle
	assign bit_here  = mask_q[idx_q];
	assign hit_above = bit_here && (idx_q > cur_q);
	assign hit_below = bit_here && (idx_q < cur_q);

	// turn at the extreme stops; the down rule wins for a single stop here
	always_comb begin
		cur_bit      = mask_q[cur_q];
		dir_turn     = dir_q;
		if (cur_bit && !any_below_q)
			dir_turn = 1'b1;
		if (cur_bit && !any_above_q)
			dir_turn = 1'b0;
		mask_cleared = mask_q & ~(esc_pkg::stop_mask_t'(1) << cur_q);
		// nothing ahead: reverse
		if (dir_turn)
			dir_fin = any_above_q;
		else
			dir_fin = !any_below_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mask_q       <= '0;
			cur_q        <= esc_pkg::CUR_FLOOR_RST;
			dir_q        <= 1'b1;
			load_q       <= '0;
			max_weight_q <= esc_pkg::MAX_WEIGHT_RST;
			min_floor_q  <= esc_pkg::MIN_FLOOR_RST;
			max_floor_q  <= esc_pkg::MAX_FLOOR_RST;
			done_q       <= 1'b0;
			status_q     <= esc_pkg::ST_OK;
			idx_q        <= '0;
			any_above_q  <= 1'b0;
			any_below_q  <= 1'b0;
			near_above_q <= '0;
			near_below_q <= '0;
		end else begin
			done_q <= 1'b0;

			if (cfg_wr) begin
				case (cfg_index)
					esc_pkg::REG_MAX_WEIGHT: max_weight_q <= cfg_data;
					esc_pkg::REG_MIN_FLOOR:  min_floor_q  <= cfg_data[esc_pkg::FLOOR_W-1:0];
					esc_pkg::REG_MAX_FLOOR:  max_floor_q  <= cfg_data[esc_pkg::FLOOR_W-1:0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= esc_pkg::ST_OK;
						case (cmd)
							esc_pkg::CMD_ADD_STOP: begin
								done_q <= 1'b1;
								if (floor_ok)
									mask_q <= mask_q | (esc_pkg::stop_mask_t'(1) << floor);
								else
									status_q <= esc_pkg::ST_REJECTED;
							end
							esc_pkg::CMD_ADD_LOAD: begin
								done_q <= 1'b1;
								if (load_sum > {1'b0, esc_pkg::LOAD_MAX})
									load_q <= esc_pkg::LOAD_MAX;
								else
									load_q <= load_sum[esc_pkg::LOAD_W-1:0];
							end
							esc_pkg::CMD_REMOVE_LOAD: begin
								done_q <= 1'b1;
								if (weight > load_q)
									load_q <= '0;
								else
									load_q <= load_q - weight;
							end
							default: begin
								if (mask_q == '0) begin
									done_q   <= 1'b1;
									status_q <= esc_pkg::ST_NO_STOPS;
								end else begin
									state_q     <= S_SCAN;
									idx_q       <= '0;
									any_above_q <= 1'b0;
									any_below_q <= 1'b0;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					// first stop above, last stop below
					if (hit_above && !any_above_q)
						near_above_q <= idx_q;
					if (hit_above)
						any_above_q <= 1'b1;
					if (hit_below) begin
						any_below_q  <= 1'b1;
						near_below_q <= idx_q;
					end
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_IDX)
						state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					mask_q  <= mask_cleared;
					dir_q   <= dir_turn;
					if (!any_above_q && !any_below_q) begin
						status_q <= esc_pkg::ST_NO_STOPS;
					end else if (load_q > max_weight_q) begin
						status_q <= esc_pkg::ST_OVERLOAD;
					end else begin
						status_q <= esc_pkg::ST_OK;
						dir_q    <= dir_fin;
						cur_q    <= dir_fin ? near_above_q : near_below_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign now_floor     = cur_q;
	assign going_up      = dir_q;
	assign pending_stops = mask_q;
	assign cabin_load    = load_q;

endmodule

`default_nettype wire

FILE: design/esc_checker.sv
// port-level checks for the elevator stop scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module esc_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            start,
	input wire                            busy,
	input wire [esc_pkg::CMD_W-1:0]       cmd,
	input wire                            done,
	input wire [esc_pkg::STATUS_W-1:0]    status,
	input wire [esc_pkg::FLOOR_W-1:0]     now_floor,
	input wire [esc_pkg::NUM_FLOORS-1:0]  pending_stops,
	input wire [esc_pkg::LOAD_W-1:0]      cabin_load
);

	// a result always closes the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

	// non-travel commands answer in the next cycle
	a_short_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd != esc_pkg::CMD_STEP) |=> done)
		else $error("short command gave no result");

	// the stop set holds while the scanner walks
	a_mask_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $stable(pending_stops))
		else $error("stop set changed during a scan");

	// an empty-set answer never moves the cabin
	a_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == esc_pkg::ST_NO_STOPS) |-> $stable(now_floor))
		else $error("cabin moved with no stops pending");

	// adding load never lowers it and reports OK
	a_load_up: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == esc_pkg::CMD_ADD_LOAD)
		|=> (cabin_load >= $past(cabin_load) && status == esc_pkg::ST_OK))
		else $error("add load lowered the cabin load");

endmodule

bind elevator_stop_scheduler esc_checker u_esc_checker (.*);

`default_nettype wire
